/* rtl/core/eurm_pkg.sv */
// Package for the yaw-pitch-roll rotation matrix: widths, constants and the CORDIC table.
`default_nettype none
package eurm_pkg;
	localparam int ANGLE_WIDTH = 16;
	localparam int ENTRY_WIDTH = 16;
	localparam int CW = 36;
	localparam int STEPS = 32;
	localparam int NSC = 6;

	typedef logic signed [CW-1:0] q30_t;
	typedef logic signed [ANGLE_WIDTH-1:0] angle_t;
	typedef logic signed [ENTRY_WIDTH-1:0] entry_t;

	typedef struct packed {
		angle_t yaw_angle;
		angle_t pitch_angle;
		angle_t roll_angle;
	} angles_t;

	typedef struct packed {
		entry_t entry_r0c0;
		entry_t entry_r0c1;
		entry_t entry_r0c2;
		entry_t entry_r1c0;
		entry_t entry_r1c1;
		entry_t entry_r1c2;
		entry_t entry_r2c0;
		entry_t entry_r2c1;
		entry_t entry_r2c2;
	} matrix_t;

	localparam q30_t Q30_PI = 36'sd3373259426;
	localparam q30_t Q30_TWO_PI = 36'sd6746518852;
	localparam q30_t Q30_HALF_PI = 36'sd1686629713;
	localparam q30_t CORDIC_GAIN = 36'sd652032874;

	function automatic q30_t atan_q30(input logic [4:0] i);
		unique case (i)
			5'd0: atan_q30 = 36'sd843314856;
			5'd1: atan_q30 = 36'sd497837829;
			5'd2: atan_q30 = 36'sd263043836;
			5'd3: atan_q30 = 36'sd133525158;
			5'd4: atan_q30 = 36'sd67021686;
			5'd5: atan_q30 = 36'sd33543515;
			5'd6: atan_q30 = 36'sd16775850;
			5'd7: atan_q30 = 36'sd8388437;
			5'd8: atan_q30 = 36'sd4194282;
			5'd9: atan_q30 = 36'sd2097149;
			5'd10: atan_q30 = 36'sd1048575;
			5'd11: atan_q30 = 36'sd524287;
			5'd12: atan_q30 = 36'sd262143;
			5'd13: atan_q30 = 36'sd131071;
			5'd14: atan_q30 = 36'sd65535;
			5'd15: atan_q30 = 36'sd32767;
			5'd16: atan_q30 = 36'sd16383;
			5'd17: atan_q30 = 36'sd8191;
			5'd18: atan_q30 = 36'sd4095;
			5'd19: atan_q30 = 36'sd2047;
			5'd20: atan_q30 = 36'sd1023;
			5'd21: atan_q30 = 36'sd511;
			5'd22: atan_q30 = 36'sd255;
			5'd23: atan_q30 = 36'sd127;
			5'd24: atan_q30 = 36'sd63;
			5'd25: atan_q30 = 36'sd31;
			5'd26: atan_q30 = 36'sd15;
			5'd27: atan_q30 = 36'sd8;
			5'd28: atan_q30 = 36'sd4;
			5'd29: atan_q30 = 36'sd2;
			5'd30: atan_q30 = 36'sd1;
			default: atan_q30 = 36'sd0;
		endcase
	endfunction
endpackage
`default_nettype wire

/* rtl/core/eurm_stream_if.sv */
// Valid/ready stream interfaces for angle and matrix items.
`default_nettype none
interface eurm_angle_if;
	logic valid;
	logic ready;
	eurm_pkg::angles_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface eurm_matrix_if;
	logic valid;
	logic ready;
	eurm_pkg::matrix_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/core/euler_rotation_matrix_3x3.sv */
// Pipeline stages: reduce, 32 CORDIC stages, fold, 5 product/sum stages, delay, round.
// Throughput: one item per cycle; every stage holds while the output item waits.
// Sine and cosine of the three angles run in three CORDIC lanes per stage.
// Reset clears only the stage valid bits; payload registers are not reset.
// The products use 36x36 multipliers in two half-width partials over two stages.
`default_nettype none
module euler_rotation_matrix_3x3 (
	input wire logic clk,
	input wire logic arst_n,
	eurm_angle_if.sink in_ch,
	eurm_matrix_if.source out_ch
);
	localparam int NS = eurm_pkg::STEPS;
	localparam int NST = NS + 9;

	logic [NST-1:0] vld_q;
	logic adv;
	assign adv = !out_ch.valid || out_ch.ready;
	assign in_ch.ready = adv;
	assign out_ch.valid = vld_q[NST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NST-2:0], in_ch.valid};
		end
	end

	// Stage 1: widen and reduce into [-pi, pi], then fold to [-pi/2, pi/2].
	eurm_pkg::q30_t z_s1 [3];
	logic neg_s1 [3];
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int a = 0; a < 3; a++) begin
				eurm_pkg::q30_t z;
				logic n;
				unique case (a)
					0: z = eurm_pkg::q30_t'(in_ch.data.yaw_angle) <<< (33 - eurm_pkg::ANGLE_WIDTH);
					1: z = eurm_pkg::q30_t'(in_ch.data.pitch_angle) <<< (33 - eurm_pkg::ANGLE_WIDTH);
					default: z = eurm_pkg::q30_t'(in_ch.data.roll_angle) <<< (33 - eurm_pkg::ANGLE_WIDTH);
				endcase
				if (z > eurm_pkg::Q30_PI) z = z - eurm_pkg::Q30_TWO_PI;
				if (z < -eurm_pkg::Q30_PI) z = z + eurm_pkg::Q30_TWO_PI;
				n = 1'b0;
				if (z > eurm_pkg::Q30_HALF_PI) begin
					z = z - eurm_pkg::Q30_PI; n = 1'b1;
				end else if (z < -eurm_pkg::Q30_HALF_PI) begin
					z = z + eurm_pkg::Q30_PI; n = 1'b1;
				end
				z_s1[a] <= z;
				neg_s1[a] <= n;
			end
		end
	end

	// CORDIC pipeline: one rotation per stage for each of the three angles.
	eurm_pkg::q30_t cx_q [NS+1][3];
	eurm_pkg::q30_t cy_q [NS+1][3];
	eurm_pkg::q30_t cz_q [NS+1][3];
	logic cn_q [NS+1][3];
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			cx_q[0][a] = eurm_pkg::CORDIC_GAIN;
			cy_q[0][a] = '0;
			cz_q[0][a] = z_s1[a];
			cn_q[0][a] = neg_s1[a];
		end
	end
	for (genvar i = 0; i < NS; i++) begin : g_cordic
		always_ff @(posedge clk) begin
			if (adv) begin
				for (int a = 0; a < 3; a++) begin
					if (!cz_q[i][a][eurm_pkg::CW-1]) begin
						cx_q[i+1][a] <= cx_q[i][a] - (cy_q[i][a] >>> i);
						cy_q[i+1][a] <= cy_q[i][a] + (cx_q[i][a] >>> i);
						cz_q[i+1][a] <= cz_q[i][a] - eurm_pkg::atan_q30(5'(i));
					end else begin
						cx_q[i+1][a] <= cx_q[i][a] + (cy_q[i][a] >>> i);
						cy_q[i+1][a] <= cy_q[i][a] - (cx_q[i][a] >>> i);
						cz_q[i+1][a] <= cz_q[i][a] + eurm_pkg::atan_q30(5'(i));
					end
					cn_q[i+1][a] <= cn_q[i][a];
				end
			end
		end
	end

	// Fold stage: apply the quadrant negation. Index 0 yaw, 1 pitch, 2 roll.
	eurm_pkg::q30_t s_s2 [3];
	eurm_pkg::q30_t c_s2 [3];
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int a = 0; a < 3; a++) begin
				s_s2[a] <= cn_q[NS][a] ? -cy_q[NS][a] : cy_q[NS][a];
				c_s2[a] <= cn_q[NS][a] ? -cx_q[NS][a] : cx_q[NS][a];
			end
		end
	end

	// Q30 product floor((a*b)/2^30) in two stages: partials, then combine.
	function automatic logic signed [71:0] plo(input eurm_pkg::q30_t a, input eurm_pkg::q30_t b);
		plo = 72'(signed'(a)) * 72'(signed'({1'b0, b[17:0]}));
	endfunction
	function automatic logic signed [71:0] phi(input eurm_pkg::q30_t a, input eurm_pkg::q30_t b);
		phi = 72'(signed'(a)) * 72'(signed'(b[35:18]));
	endfunction
	function automatic eurm_pkg::q30_t comb(input logic signed [71:0] lo,
			input logic signed [71:0] hi);
		logic signed [71:0] t;
		t = lo + (hi <<< 18);
		comb = eurm_pkg::q30_t'(t >>> 30);
	endfunction

	// First product layer: sr*sp, cr*sp.
	logic signed [71:0] p1l_s3 [2];
	logic signed [71:0] p1h_s3 [2];
	eurm_pkg::q30_t s_s3 [3];
	eurm_pkg::q30_t c_s3 [3];
	always_ff @(posedge clk) begin
		if (adv) begin
			p1l_s3[0] <= plo(s_s2[2], s_s2[1]);
			p1h_s3[0] <= phi(s_s2[2], s_s2[1]);
			p1l_s3[1] <= plo(c_s2[2], s_s2[1]);
			p1h_s3[1] <= phi(c_s2[2], s_s2[1]);
			s_s3 <= s_s2;
			c_s3 <= c_s2;
		end
	end
	eurm_pkg::q30_t srsp_s4, crsp_s4;
	eurm_pkg::q30_t s_s4 [3];
	eurm_pkg::q30_t c_s4 [3];
	always_ff @(posedge clk) begin
		if (adv) begin
			srsp_s4 <= comb(p1l_s3[0], p1h_s3[0]);
			crsp_s4 <= comb(p1l_s3[1], p1h_s3[1]);
			s_s4 <= s_s3;
			c_s4 <= c_s3;
		end
	end

	// Second layer: 13 products, A/B operand pairs.
	localparam int NP = 13;
	eurm_pkg::q30_t pa [NP];
	eurm_pkg::q30_t pb [NP];
	always_comb begin
		pa[0] = c_s4[2]; pb[0] = c_s4[0];
		pa[1] = srsp_s4; pb[1] = s_s4[0];
		pa[2] = s_s4[2]; pb[2] = c_s4[1];
		pa[3] = c_s4[2]; pb[3] = -s_s4[0];
		pa[4] = srsp_s4; pb[4] = c_s4[0];
		pa[5] = -s_s4[2]; pb[5] = c_s4[0];
		pa[6] = crsp_s4; pb[6] = s_s4[0];
		pa[7] = c_s4[2]; pb[7] = c_s4[1];
		pa[8] = s_s4[2]; pb[8] = s_s4[0];
		pa[9] = crsp_s4; pb[9] = c_s4[0];
		pa[10] = c_s4[1]; pb[10] = s_s4[0];
		pa[11] = c_s4[1]; pb[11] = c_s4[0];
		pa[12] = -s_s4[1]; pb[12] = 36'sd1073741824;
	end
	logic signed [71:0] pl_s5 [NP];
	logic signed [71:0] ph_s5 [NP];
	eurm_pkg::q30_t pr_s6 [NP];
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < NP; k++) begin
				pl_s5[k] <= plo(pa[k], pb[k]);
				ph_s5[k] <= phi(pa[k], pb[k]);
			end
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < NP; k++) pr_s6[k] <= comb(pl_s5[k], ph_s5[k]);
		end
	end

	// Sums.
	eurm_pkg::q30_t sum_s7 [9];
	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s7[0] <= pr_s6[0] + pr_s6[1];
			sum_s7[1] <= pr_s6[2];
			sum_s7[2] <= pr_s6[3] + pr_s6[4];
			sum_s7[3] <= pr_s6[5] + pr_s6[6];
			sum_s7[4] <= pr_s6[7];
			sum_s7[5] <= pr_s6[8] + pr_s6[9];
			sum_s7[6] <= pr_s6[10];
			sum_s7[7] <= pr_s6[12];
			sum_s7[8] <= pr_s6[11];
		end
	end

	// Round half up and saturate.
	localparam int SH = 32 - eurm_pkg::ENTRY_WIDTH;
	localparam eurm_pkg::q30_t ONE = eurm_pkg::q30_t'(1) <<< (eurm_pkg::ENTRY_WIDTH - 2);
	function automatic eurm_pkg::entry_t to_entry(input eurm_pkg::q30_t v);
		eurm_pkg::q30_t r;
		if (SH > 0) r = (v + (eurm_pkg::q30_t'(1) <<< (SH - 1))) >>> SH;
		else r = v;
		if (r > ONE) r = ONE;
		if (r < -ONE) r = -ONE;
		to_entry = eurm_pkg::entry_t'(r);
	endfunction

	eurm_pkg::q30_t sum_s8 [9];
	always_ff @(posedge clk) begin
		if (adv) sum_s8 <= sum_s7;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			out_ch.data.entry_r0c0 <= to_entry(sum_s8[0]);
			out_ch.data.entry_r0c1 <= to_entry(sum_s8[1]);
			out_ch.data.entry_r0c2 <= to_entry(sum_s8[2]);
			out_ch.data.entry_r1c0 <= to_entry(sum_s8[3]);
			out_ch.data.entry_r1c1 <= to_entry(sum_s8[4]);
			out_ch.data.entry_r1c2 <= to_entry(sum_s8[5]);
			out_ch.data.entry_r2c0 <= to_entry(sum_s8[6]);
			out_ch.data.entry_r2c1 <= to_entry(sum_s8[7]);
			out_ch.data.entry_r2c2 <= to_entry(sum_s8[8]);
		end
	end
endmodule
`default_nettype wire

/* bench/euler_rotation_matrix_3x3_test.sv */
// Stream test of the yaw-pitch-roll rotation matrix against a bit-exact CORDIC predictor.
`timescale 1ns / 100ps
`default_nettype none
module euler_rotation_matrix_3x3_test;
	localparam longint PI_Q30 = 64'sd3373259426;
	localparam longint TWO_PI_Q30 = 64'sd6746518852;
	localparam longint HALF_PI_Q30 = 64'sd1686629713;
	localparam longint GAIN_Q30 = 64'sd652032874;
	localparam int RANDOM_ITEMS = 1100;

	// Arctangent steps of the CORDIC, Q30.
	localparam longint ARCTAN [32] = '{
		843314856, 497837829, 263043836, 133525158, 67021686,
		33543515, 16775850, 8388437, 4194282, 2097149,
		1048575, 524287, 262143, 131071, 65535, 32767,
		16383, 8191, 4095, 2047, 1023, 511, 255, 127,
		63, 31, 15, 8, 4, 2, 1, 0};

	class matrix_scoreboard;
		eurm_pkg::matrix_t pending[$];
		int errors;
		int matched;

		function void sine_cosine(input eurm_pkg::angle_t a, output longint s,
				output longint c);
			longint z, x, y, t;
			bit flip;
			z = longint'(a) <<< (30 - (eurm_pkg::ANGLE_WIDTH - 3));
			x = GAIN_Q30;
			y = 0;
			flip = 0;
			if (z > PI_Q30) z -= TWO_PI_Q30;
			if (z < -PI_Q30) z += TWO_PI_Q30;
			if (z > HALF_PI_Q30) begin
				z -= PI_Q30;
				flip = 1;
			end else if (z < -HALF_PI_Q30) begin
				z += PI_Q30;
				flip = 1;
			end
			for (int i = 0; i < 32; i++) begin
				if (z >= 0) begin
					t = x - (y >>> i);
					y = y + (x >>> i);
					z -= ARCTAN[i];
				end else begin
					t = x + (y >>> i);
					y = y - (x >>> i);
					z += ARCTAN[i];
				end
				x = t;
			end
			if (flip) begin
				x = -x;
				y = -y;
			end
			s = y;
			c = x;
		endfunction

		function longint fmul(input longint a, input longint b);
			return (a * b) >>> 30;
		endfunction

		function eurm_pkg::entry_t round_entry(input longint v);
			longint one;
			one = longint'(1) <<< (eurm_pkg::ENTRY_WIDTH - 2);
			v = (v + (longint'(1) <<< (30 - eurm_pkg::ENTRY_WIDTH + 1)))
				>>> (30 - eurm_pkg::ENTRY_WIDTH + 2);
			if (v > one) v = one;
			if (v < -one) v = -one;
			return eurm_pkg::entry_t'(v);
		endfunction

		function void note_angles(input eurm_pkg::angles_t a);
			longint sy, cy, sp, cp, sr, cr, srsp, crsp;
			eurm_pkg::matrix_t m;
			sine_cosine(a.yaw_angle, sy, cy);
			sine_cosine(a.pitch_angle, sp, cp);
			sine_cosine(a.roll_angle, sr, cr);
			srsp = fmul(sr, sp);
			crsp = fmul(cr, sp);
			m.entry_r0c0 = round_entry(fmul(cr, cy) + fmul(srsp, sy));
			m.entry_r0c1 = round_entry(fmul(sr, cp));
			m.entry_r0c2 = round_entry(fmul(cr, -sy) + fmul(srsp, cy));
			m.entry_r1c0 = round_entry(fmul(-sr, cy) + fmul(crsp, sy));
			m.entry_r1c1 = round_entry(fmul(cr, cp));
			m.entry_r1c2 = round_entry(fmul(sr, sy) + fmul(crsp, cy));
			m.entry_r2c0 = round_entry(fmul(cp, sy));
			m.entry_r2c1 = round_entry(-sp);
			m.entry_r2c2 = round_entry(fmul(cp, cy));
			pending.push_back(m);
		endfunction

		function void check_entry(input string name, input eurm_pkg::entry_t exp_v,
				input eurm_pkg::entry_t act_v);
			if (exp_v !== act_v) begin
				$error("%s: expected %0d, got %0d", name, exp_v, act_v);
				errors++;
			end
		endfunction

		function void check_matrix(input eurm_pkg::matrix_t m);
			eurm_pkg::matrix_t e;
			if (pending.size() == 0) begin
				$error("matrix item arrived with none expected");
				errors++;
				return;
			end
			e = pending.pop_front();
			matched++;
			check_entry("entry_r0c0", e.entry_r0c0, m.entry_r0c0);
			check_entry("entry_r0c1", e.entry_r0c1, m.entry_r0c1);
			check_entry("entry_r0c2", e.entry_r0c2, m.entry_r0c2);
			check_entry("entry_r1c0", e.entry_r1c0, m.entry_r1c0);
			check_entry("entry_r1c1", e.entry_r1c1, m.entry_r1c1);
			check_entry("entry_r1c2", e.entry_r1c2, m.entry_r1c2);
			check_entry("entry_r2c0", e.entry_r2c0, m.entry_r2c0);
			check_entry("entry_r2c1", e.entry_r2c1, m.entry_r2c1);
			check_entry("entry_r2c2", e.entry_r2c2, m.entry_r2c2);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	eurm_angle_if in_ch ();
	eurm_matrix_if out_ch ();
	matrix_scoreboard board;
	bit no_idle;
	bit hold_off;

	euler_rotation_matrix_3x3 u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	function automatic bit idle_now();
		return !no_idle && ($urandom_range(99) < 37);
	endfunction

	function automatic eurm_pkg::angle_t random_angle();
		case ($urandom_range(5))
			0: return eurm_pkg::angle_t'($urandom_range(65535));
			1: return eurm_pkg::angle_t'(25736 - 6 + $urandom_range(12));
			2: return eurm_pkg::angle_t'(-25736 - 6 + $urandom_range(12));
			3: return eurm_pkg::angle_t'(12868 - 6 + $urandom_range(12));
			4: return eurm_pkg::angle_t'(-12868 - 6 + $urandom_range(12));
			default: return eurm_pkg::angle_t'($urandom_range(65535));
		endcase
	endfunction

	// Valid drops only for idle cycles, so back-to-back items keep it high.
	task automatic send_angles(input eurm_pkg::angles_t a);
		if (idle_now()) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
			while (idle_now()) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= a;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		board.note_angles(a);
	endtask

	// Receiver: sample accepted items at the edge, update ready for the next one.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) board.check_matrix(out_ch.data);
			out_ch.ready <= !hold_off && !idle_now();
		end
	end

	initial begin
		eurm_pkg::angle_t edges [10];
		board = new();
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
		no_idle = 0;
		hold_off = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// Extremes, zero, near +-pi and +-pi/2 where reduction and folding switch.
		edges = '{16'sh7fff, 16'sh8000, 16'sd0, 16'sd25736, -16'sd25736,
			16'sd25737, 16'sd12868, -16'sd12868, 16'sd12869, 16'sd1};
		for (int i = 0; i < 10; i++)
			send_angles('{edges[i], edges[(i + 3) % 10], edges[(i + 7) % 10]});
		send_angles('{16'sh7fff, 16'sh7fff, 16'sh7fff});
		send_angles('{16'sh8000, 16'sh8000, 16'sh8000});
		send_angles('{16'sh5555, 16'shaaaa, 16'sh5555});
		send_angles('{16'shaaaa, 16'sh5555, 16'shaaaa});
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			no_idle = (n >= 300 && n < 450);
			if (n == 600) hold_off = 1;
			send_angles('{random_angle(), random_angle(), random_angle()});
		end
		in_ch.valid <= 1'b0;
		no_idle = 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		$display("Checked %0d matrices over edge angles, random angles near the reduction",
			board.matched);
		$display("and folding bounds, back-to-back streams and a long output stall.");
		if (board.errors == 0 && board.pending.size() == 0)
			$display("euler_rotation_matrix_3x3 verification clean");
		else
			$display("euler_rotation_matrix_3x3 verification failed");
		$finish;
	end

	// Long output stall while the sender keeps offering items.
	initial begin
		wait (hold_off);
		repeat (200) @(posedge clk);
		hold_off = 0;
	end

	initial begin
		#5ms;
		$display("euler_rotation_matrix_3x3 verification failed");
		$finish;
	end
endmodule
`default_nettype wire
